/* sv/assert_macros.svh */
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, disabled while reset is low.
`define ARTS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Property checked on every rising edge, reset included.
`define ARTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) \
		else $error(msg);

`endif

/* sv/arts_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the address range table search unit.
// Used by every module of the block; depends on nothing.
package arts_pkg;

	localparam int SLOT_W   = 10;
	localparam int ADDR_W   = 64;
	localparam int LEN_W    = 32;
	localparam int COUNT_W  = 11;
	localparam int DATA_W   = 64;
	localparam int APB_ADDR_W = 5;

	// Register index sits in paddr[4:3]; registers are 8 bytes apart.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_START = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_WINDOW_END   = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ENTRY_COUNT  = 2'd2;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_LOOKUP = 1'b1;

	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic              action;
		logic [SLOT_W-1:0] entry_slot;
		logic [ADDR_W-1:0] range_start;
		logic [LEN_W-1:0]  range_length;
		logic [ADDR_W-1:0] query_address;
	} req_t;

	typedef struct packed {
		logic              hit;
		logic [SLOT_W-1:0] found_slot;
		logic [LEN_W-1:0]  range_offset;
	} rsp_t;

	typedef enum logic [1:0] {
		JOB_LOAD,
		JOB_SEARCH,
		JOB_MISS
	} job_kind_t;

	typedef struct packed {
		job_kind_t         kind;
		logic [SLOT_W-1:0] slot;
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
		logic [ADDR_W-1:0] address;
	} job_t;

	typedef struct packed {
		logic [ADDR_W-1:0] start;
		logic [LEN_W-1:0]  length;
	} tbl_entry_t;

endpackage

/* sv/arts_front.sv */
`timescale 1ns / 1ps
// Front end: takes request beats into an input register and classifies them
// into load, search or miss jobs for the queue. Depends on arts_pkg.
module arts_front #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  arts_pkg::req_t                    req,
	input  logic [arts_pkg::ADDR_W-1:0]       window_start,
	input  logic [arts_pkg::ADDR_W-1:0]       window_end,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
	input  logic                              q_full,
	output logic                              q_push,
	output arts_pkg::job_t                    q_job
);
	import arts_pkg::*;

	logic        valid_s1;
	req_t        item_s1;
	logic        drop;
	logic        take;
	logic        in_window;
	logic [31:0] slot_wide;

	always_comb begin
		slot_wide = 32'(item_s1.entry_slot);
		in_window = (item_s1.query_address >= window_start) &&
			(item_s1.query_address < window_end);
		q_job.slot    = item_s1.entry_slot;
		q_job.start   = item_s1.range_start;
		q_job.length  = item_s1.range_length;
		q_job.address = item_s1.query_address;
		drop = 1'b0;
		priority if (item_s1.action == ACT_LOAD) begin
			q_job.kind = JOB_LOAD;
			// drop loads aimed past the end of the table
			drop = (slot_wide >= 32'(TABLE_DEPTH));
		end else if (in_window && (count != '0)) begin
			q_job.kind = JOB_SEARCH;
		end else begin
			q_job.kind = JOB_MISS;
		end
		take      = valid_s1 && (drop || !q_full);
		q_push    = valid_s1 && !drop && !q_full;
		req_ready = !valid_s1 || take;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req;
		end
	end

endmodule

/* sv/arts_queue.sv */
`timescale 1ns / 1ps
// Short job queue between the front end and the search engine.
// Depends on arts_pkg.
module arts_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  arts_pkg::job_t push_job,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output arts_pkg::job_t head
);
	import arts_pkg::*;

	job_t              slots_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   cnt_q;
	logic              do_push;
	logic              do_pop;

	always_comb begin
		full    = (cnt_q == (QPTR_W + 1)'(QUEUE_DEPTH));
		valid   = (cnt_q != '0);
		head    = slots_q[rd_ptr_q];
		do_push = push && !full;
		do_pop  = pop && valid;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + (QPTR_W + 1)'(1);
				2'b01:   cnt_q <= cnt_q - (QPTR_W + 1)'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_job;
		end
	end

endmodule

/* sv/arts_back.sv */
`timescale 1ns / 1ps
// Search engine: owns the range table RAM, writes loads and runs the binary
// search for lookups, one probe per RAM read. Depends on arts_pkg.
module arts_back #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              q_valid,
	output logic                              q_pop,
	input  arts_pkg::job_t                    q_job,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]  count,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output arts_pkg::rsp_t                    rsp
);
	import arts_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ISSUE,
		ST_EVAL
	} state_t;

	state_t            state_q;
	logic [AW-1:0]     left_q;
	logic [AW-1:0]     right_q;
	logic [AW-1:0]     probe_q;
	logic              last_q;
	logic [ADDR_W-1:0] addr_q;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	tbl_entry_t        tbl_mem [TABLE_DEPTH];
	tbl_entry_t        rd_q;

	logic              out_free;
	logic              rsp_load;
	logic [AW:0]       sum;
	logic [AW-1:0]     mid;
	logic              narrow;
	logic              we;
	logic              re;
	logic [AW-1:0]     waddr;
	logic [AW-1:0]     raddr;
	logic [31:0]       slot_wide;
	logic [31:0]       right_wide;
	logic [31:0]       probe_wide;
	logic [31:0]       next_left_wide;
	logic [ADDR_W-1:0] diff;
	logic              at_or_above;
	logic              holds;

	always_comb begin
		out_free   = !rsp_valid_q || rsp_ready;
		sum        = {1'b0, left_q} + {1'b0, right_q};
		mid        = sum[AW:1];
		narrow     = (left_q < right_q);
		raddr      = narrow ? mid : left_q;
		slot_wide  = 32'(q_job.slot);
		waddr      = slot_wide[AW-1:0];
		right_wide = 32'(count) - 32'd1;
		probe_wide = 32'(probe_q);
		next_left_wide = probe_wide + 32'd1;

		// probe compare: start <= addr and addr - start < length, no wrap
		diff        = addr_q - rd_q.start;
		at_or_above = (addr_q >= rd_q.start);
		holds       = at_or_above && (diff[ADDR_W-1:LEN_W] == '0) &&
			(diff[LEN_W-1:0] < rd_q.length);

		q_pop = (state_q == ST_IDLE) && q_valid &&
			((q_job.kind != JOB_MISS) || out_free);
		we = q_pop && (q_job.kind == JOB_LOAD);
		re = (state_q == ST_ISSUE);
		// a new response beat enters the output register
		rsp_load = (q_pop && (q_job.kind == JOB_MISS)) ||
			((state_q == ST_EVAL) && (holds || last_q) && out_free);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			tbl_mem[waddr] <= '{start: q_job.start, length: q_job.length};
		end
		if (re) begin
			rd_q <= tbl_mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			left_q      <= '0;
			right_q     <= '0;
			probe_q     <= '0;
			last_q      <= 1'b0;
			addr_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop) begin
						unique case (q_job.kind)
							JOB_SEARCH: begin
								left_q  <= '0;
								right_q <= right_wide[AW-1:0];
								addr_q  <= q_job.address;
								state_q <= ST_ISSUE;
							end
							JOB_MISS: begin
								rsp_q <= '0;
							end
							default: begin
								// load: written to the table this cycle
							end
						endcase
					end
				end
				ST_ISSUE: begin
					probe_q <= raddr;
					last_q  <= !narrow;
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (holds || last_q) begin
						// hold the verdict until the output register frees up
						if (out_free) begin
							if (holds) begin
								rsp_q.hit          <= 1'b1;
								rsp_q.found_slot   <= probe_wide[SLOT_W-1:0];
								rsp_q.range_offset <= diff[LEN_W-1:0];
							end else begin
								rsp_q <= '0;
							end
							state_q <= ST_IDLE;
						end
					end else begin
						if (!at_or_above) begin
							right_q <= probe_q;
						end else begin
							left_q <= next_left_wide[AW-1:0];
						end
						state_q <= ST_ISSUE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

/* sv/address_range_table_search_unit.sv */
`timescale 1ns / 1ps
// Address range table search unit: a table of TABLE_DEPTH sorted ranges,
// loaded one entry per request beat and searched by address lookups.
// The search engine runs one job at a time. A load, or a lookup that
// misses on the window or an empty table, ends as the engine takes it.
// A searching lookup runs P probes, at most ceil(log2(count)) plus one
// (11 probes for 1024 entries); each probe is one read of the table
// RAM followed by a compare of the entry read against the address. An input
// register and a two-entry job queue let requests keep arriving while the
// engine works, and an output register holds a finished response while the
// next job runs. Configuration sits on the APB port: window_start at 0x00,
// window_end at 0x08, entry_count at 0x10. The table RAM is not cleared;
// search only entries that were loaded. Depends on arts_pkg, arts_front,
// arts_queue and arts_back.
module address_range_table_search_unit #(
	parameter int TABLE_DEPTH = 1024
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [arts_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [arts_pkg::DATA_W-1:0]       pwdata,
	output logic [arts_pkg::DATA_W-1:0]       prdata,
	output logic                              pready,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  arts_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output arts_pkg::rsp_t                    rsp
);
	import arts_pkg::*;

	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [ADDR_W-1:0]    window_start_q;
	logic [ADDR_W-1:0]    window_end_q;
	logic [COUNT_W-1:0]   entry_count_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;
	logic [31:0]          count_wide;
	logic [CW-1:0]        count;

	logic q_full;
	logic q_push;
	job_t q_in;
	logic q_valid;
	logic q_pop;
	job_t q_head;

	always_comb begin
		reg_idx = paddr[APB_ADDR_W-1:APB_ADDR_W-REG_IDX_W];
		wr_en   = psel && penable && pwrite && pready;
		unique case (reg_idx)
			REG_WINDOW_START: prdata = window_start_q;
			REG_WINDOW_END:   prdata = window_end_q;
			REG_ENTRY_COUNT:  prdata = DATA_W'(entry_count_q);
			default:          prdata = '0;
		endcase
		// clamp the searched count to the table size
		count_wide = (32'(entry_count_q) > 32'(TABLE_DEPTH)) ?
			32'(TABLE_DEPTH) : 32'(entry_count_q);
		count = count_wide[CW-1:0];
	end

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_start_q <= '0;
			window_end_q   <= '0;
			entry_count_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_WINDOW_START: window_start_q <= pwdata;
				REG_WINDOW_END:   window_end_q   <= pwdata;
				REG_ENTRY_COUNT:  entry_count_q  <= pwdata[COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	arts_front #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.window_start(window_start_q),
		.window_end  (window_end_q),
		.count       (count),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_in)
	);

	arts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.push_job(q_in),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.head    (q_head)
	);

	arts_back #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_pop    (q_pop),
		.q_job    (q_head),
		.count    (count),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp)
	);

endmodule

/* sv/arts_checker.sv */
`timescale 1ns / 1ps
// Port-level checks of the address range table search unit, bound to the
// top level. Depends on arts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module arts_checker #(
	parameter int TABLE_DEPTH = 1024
) (
	input logic           clk,
	input logic           arst_n,
	input logic           pready,
	input logic           rsp_valid,
	input logic           rsp_ready,
	input arts_pkg::rsp_t rsp
);
	import arts_pkg::*;

	// a stalled response beat stays put
	`ARTS_ASSERT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "response beat changed while stalled")

	// a miss reports no slot and no offset
	`ARTS_ASSERT(a_miss_zero, clk, arst_n, rsp_valid && !rsp.hit |-> rsp.found_slot == '0 && rsp.range_offset == '0, "miss with nonzero slot or offset")

	// a hit names a slot inside the table
	`ARTS_ASSERT(a_hit_slot, clk, arst_n, rsp_valid && rsp.hit |-> 32'(rsp.found_slot) < 32'(TABLE_DEPTH), "hit slot past end of table")

	`ARTS_ASSERT_ALWAYS(a_pready, clk, pready, "pready dropped")

endmodule

bind address_range_table_search_unit arts_checker #(
	.TABLE_DEPTH(TABLE_DEPTH)
) u_arts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.pready   (pready),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
